>>> hw/rtl/u2r_pkg.sv
`default_nettype none

package u2r_pkg;

    localparam int TEXT_LEN   = 24;
    localparam int NUM_DIGITS = 17;

    // Bias of one full 400-year era of nanoseconds keeps the dividend non-negative
    localparam logic [64:0] EPOCH_BIAS  = 65'd12622780800000000000;
    localparam logic [19:0] DAY_SHIFT   = 20'd719468;
    localparam logic [4:0]  LAST_POS    = 5'd23;

    // Seconds split: biased ns >> 9, then divide by 5^9
    localparam logic [20:0] SEC_DIV    = 21'd1953125;
    // 2^28 == SEC_FOLD_Q * SEC_DIV + SEC_FOLD_R
    localparam logic [7:0]  SEC_FOLD_Q = 8'd137;
    localparam logic [19:0] SEC_FOLD_R = 20'd857331;
    localparam logic [29:0] M_SEC      = 30'(((64'd1 << 50) + 64'd1953124) / 64'd1953125);
    // Day split: seconds >> 7, then divide by 675
    localparam logic [9:0]  DAY_DIV    = 10'd675;
    localparam logic [29:0] M_DAY      = 30'(((64'd1 << 39) + 64'd674) / 64'd675);
    // Millisecond split: ns >> 6, then divide by 15625
    localparam logic [24:0] M_MS       = 25'(((64'd1 << 38) + 64'd15624) / 64'd15625);

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Decimal digits in text order: YYYY MM DD hh mm ss fff
    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    // Front result: shifted day number, second of day, millisecond
    typedef struct packed {
        logic [19:0] zday;
        logic [16:0] sod;
        logic [9:0]  msec;
    } split_t;

    // Split a value below 128 into tens and ones
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tn;
        logic [6:0]  t10;
        p   = 15'(v) * 15'd205;
        tn  = p[14:11];
        t10 = 7'({tn, 3'b000}) + 7'({tn, 1'b0});
        return {tn, 4'(v - t10)};
    endfunction

    // Character at a text position
    function automatic logic [7:0] char_at(input logic [4:0] pos, input digits_t dg);
        logic [4:0] di;
        logic       is_dig;
        logic [7:0] sep;
        di     = '0;
        is_dig = 1'b1;
        sep    = CH_Z;
        unique case (pos)
            5'd0, 5'd1, 5'd2, 5'd3:  di = pos;
            5'd5, 5'd6:              di = pos - 5'd1;
            5'd8, 5'd9:              di = pos - 5'd2;
            5'd11, 5'd12:            di = pos - 5'd3;
            5'd14, 5'd15:            di = pos - 5'd4;
            5'd17, 5'd18:            di = pos - 5'd5;
            5'd20, 5'd21, 5'd22:     di = pos - 5'd6;
            5'd4, 5'd7:
            begin
                is_dig = 1'b0;
                sep    = CH_DASH;
            end
            5'd10:
            begin
                is_dig = 1'b0;
                sep    = CH_T;
            end
            5'd13, 5'd16:
            begin
                is_dig = 1'b0;
                sep    = CH_COLON;
            end
            5'd19:
            begin
                is_dig = 1'b0;
                sep    = CH_DOT;
            end
            default:
            begin
                is_dig = 1'b0;
                sep    = CH_Z;
            end
        endcase
        return is_dig ? (CH_ZERO + {4'b0000, dg[di]}) : sep;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/u2r_front.sv
`default_nettype none

module u2r_front #(
    parameter int QDEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic signed [63:0] timestamp_ns,
    output logic                    full,
    input  wire logic               retire,
    output logic                    launch,
    output u2r_pkg::split_t         split
);
    import u2r_pkg::*;

    localparam int CW = $clog2(QDEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_FOLD = 7'b0000010,
        ST_QUO  = 7'b0000100,
        ST_REM  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_SOD  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic        buf_valid_reg, buf_valid_next;
    logic [63:0] buf_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic [55:0] p_reg, p_next;
    logic [8:0]  low_reg, low_next;
    logic [35:0] qacc_reg, qacc_next;
    logic [7:0]  qv_reg, qv_next;
    logic [35:0] sec_reg, sec_next;
    logic [29:0] rem_reg, rem_next;
    logic [17:0] day_reg, day_next;
    logic [9:0]  msec_reg, msec_next;
    logic [16:0] sod_reg, sod_next;
    logic [CW-1:0] credit_reg, credit_next;
    logic        launch_reg, launch_next;
    split_t      split_reg, split_next;

    logic        accept, take, fire;
    logic [64:0] biased;
    logic [27:0] fold_hi;
    logic [47:0] fold_res;
    logic [35:0] fold_quo;
    logic [58:0] pr_sec, pr_day;
    logic [48:0] pr_ms;
    logic [28:0] sec_rem, day_rem;

    assign accept = push && !buf_valid_reg;
    assign full   = buf_valid_reg;
    assign launch = launch_reg;
    assign split  = split_reg;
    assign biased = {buf_reg[63], buf_reg} + EPOCH_BIAS;
    assign fire   = (state_reg == ST_DONE) && (credit_reg < CW'(QDEPTH));
    assign take   = buf_valid_reg && ((state_reg == ST_IDLE) || fire);

    // Fold 2^28 multiples of the 5^9 divisor into the quotient, then reciprocals
    assign fold_hi  = p_reg[55:28];
    assign fold_res = 48'(fold_hi) * 48'(SEC_FOLD_R);
    assign fold_quo = 36'(fold_hi) * 36'(SEC_FOLD_Q);
    assign pr_sec   = 59'(p_reg[28:0]) * 59'(M_SEC);
    assign sec_rem  = p_reg[28:0] - 29'(29'(qv_reg) * 29'(SEC_DIV));
    assign pr_day   = 59'(sec_reg[35:7]) * 59'(M_DAY);
    assign pr_ms    = 49'(rem_reg[29:6]) * 49'(M_MS);
    assign day_rem  = sec_reg[35:7] - 29'(29'(day_reg) * 29'(DAY_DIV));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        low_next       = low_reg;
        qacc_next      = qacc_reg;
        qv_next        = qv_reg;
        sec_next       = sec_reg;
        rem_next       = rem_reg;
        day_next       = day_reg;
        msec_next      = msec_reg;
        sod_next       = sod_reg;
        launch_next    = 1'b0;
        split_next     = split_reg;
        buf_valid_next = buf_valid_reg;
        if (accept)
            buf_valid_next = 1'b1;
        else if (take)
            buf_valid_next = 1'b0;
        credit_next = credit_reg + CW'(fire) - CW'(retire);

        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (fire)
                begin
                    launch_next     = 1'b1;
                    split_next.zday = 20'(day_reg) + DAY_SHIFT;
                    split_next.sod  = sod_reg;
                    split_next.msec = msec_reg;
                    state_next      = ST_IDLE;
                end
                if (take)
                begin
                    p_next     = biased[64:9];
                    low_next   = biased[8:0];
                    qacc_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                p_next    = 56'(fold_res) + 56'(p_reg[27:0]);
                qacc_next = qacc_reg + fold_quo;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = ST_QUO;
            end
            ST_QUO:
            begin
                qv_next    = pr_sec[57:50];
                state_next = ST_REM;
            end
            ST_REM:
            begin
                sec_next   = qacc_reg + 36'(qv_reg);
                rem_next   = {sec_rem[20:0], low_reg};
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                day_next   = pr_day[56:39];
                msec_next  = pr_ms[47:38];
                state_next = ST_SOD;
            end
            ST_SOD:
            begin
                sod_next   = {day_rem[9:0], sec_reg[6:0]};
                state_next = ST_DONE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_valid_reg <= 1'b0;
            credit_reg    <= '0;
            launch_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            credit_reg    <= credit_next;
            launch_reg    <= launch_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_reg <= timestamp_ns;
        p_reg     <= p_next;
        low_reg   <= low_next;
        qacc_reg  <= qacc_next;
        qv_reg    <= qv_next;
        sec_reg   <= sec_next;
        rem_reg   <= rem_next;
        day_reg   <= day_next;
        msec_reg  <= msec_next;
        sod_reg   <= sod_next;
        split_reg <= split_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/u2r_civil.sv
`default_nettype none

module u2r_civil (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire u2r_pkg::split_t  in_split,
    output logic                  out_valid,
    output u2r_pkg::digits_t      out_digits
);
    import u2r_pkg::*;

    localparam int NST = 12;

    // Reciprocals: floor(x / c) == (x * M) >> s for every x in range
    localparam logic [20:0] M_ERA   = 21'(((64'd1 << 38) + 64'd146096) / 64'd146097);
    localparam logic [17:0] M_HOUR  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [17:0] M_MIN   = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [11:0] M_MIN2  = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
    localparam logic [10:0] M_MS100 = 11'(((64'd1 << 17) + 64'd99) / 64'd100);
    localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_146096 = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
    localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_Y100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [11:0] M_5     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
    localparam logic [12:0] M_D10   = 13'(((64'd1 << 16) + 64'd9) / 64'd10);
    localparam logic [12:0] M_D100  = 13'(((64'd1 << 19) + 64'd99) / 64'd100);
    localparam logic [12:0] M_D1000 = 13'(((64'd1 << 22) + 64'd999) / 64'd1000);

    typedef struct packed {
        logic [19:0] z;
        logic [2:0]  era;
        logic [17:0] doe;
        logic [11:0] y400;
        logic [7:0]  a;
        logic [2:0]  b;
        logic        c;
        logic [17:0] t;
        logic [8:0]  yoe;
        logic [2:0]  yc;
        logic [8:0]  doy;
        logic [11:0] yp;
        logic [10:0] n;
        logic [3:0]  mp;
        logic [10:0] k;
        logic [4:0]  d;
        logic [3:0]  mon;
        logic [11:0] year;
        logic [8:0]  q10;
        logic [5:0]  q100;
        logic [1:0]  q1000;
        logic [16:0] sod;
        logic [10:0] tmin;
        logic [4:0]  hh;
        logic [5:0]  ss;
        logic [4:0]  th;
        logic [5:0]  mm;
        logic [9:0]  ms;
        logic [3:0]  msh;
        logic [6:0]  msr;
        logic [7:0]  hh_bcd;
        logic [7:0]  mm_bcd;
        logic [7:0]  ss_bcd;
        logic [7:0]  mo_bcd;
        logic [7:0]  dy_bcd;
        logic [11:0] ms_bcd;
    } pipe_t;

    pipe_t       p_reg  [1:NST];
    pipe_t       p_next [1:NST];
    logic [NST:0] vld_reg;
    digits_t     dig_reg, dig_next;

    logic [40:0] pr_era;
    logic [34:0] pr_hour, pr_min;
    logic [20:0] pr_ms;
    logic [22:0] pr_min2, pr_mp, pr_k;
    logic [36:0] pr_a, pr_b, pr_c, pr_y;
    logic [18:0] pr_yc;
    logic [24:0] pr_10, pr_100, pr_1000;
    logic [8:0]  q5;

    // Stage 1: era, hour, total minutes, hundreds of ms
    always_comb
    begin
        p_next[1]      = '0;
        p_next[1].z    = in_split.zday;
        p_next[1].sod  = in_split.sod;
        p_next[1].ms   = in_split.msec;
        pr_era         = 41'(in_split.zday) * 41'(M_ERA);
        pr_hour        = 35'(in_split.sod) * 35'(M_HOUR);
        pr_min         = 35'(in_split.sod) * 35'(M_MIN);
        pr_ms          = 21'(in_split.msec) * 21'(M_MS100);
        p_next[1].era  = pr_era[40:38];
        p_next[1].hh   = pr_hour[33:29];
        p_next[1].tmin = pr_min[33:23];
        p_next[1].msh  = pr_ms[20:17];
    end

    // Stage 2: day of era, second, hour from minutes
    always_comb
    begin
        p_next[2]      = p_reg[1];
        p_next[2].doe  = 18'(p_reg[1].z - 20'(20'(p_reg[1].era) * 20'd146097));
        p_next[2].y400 = 12'(p_reg[1].era) * 12'd400;
        p_next[2].ss   = 6'(p_reg[1].sod - 17'(17'(p_reg[1].tmin) * 17'd60));
        pr_min2        = 23'(p_reg[1].tmin) * 23'(M_MIN2);
        p_next[2].th   = pr_min2[21:17];
        p_next[2].msr  = 7'(p_reg[1].ms - 10'(10'(p_reg[1].msh) * 10'd100));
    end

    // Stage 3: leap corrections, minute, time digits
    always_comb
    begin
        p_next[3]        = p_reg[2];
        pr_a             = 37'(p_reg[2].doe) * 37'(M_1460);
        pr_b             = 37'(p_reg[2].doe) * 37'(M_36524);
        pr_c             = 37'(p_reg[2].doe) * 37'(M_146096);
        p_next[3].a      = pr_a[36:29];
        p_next[3].b      = pr_b[36:34];
        p_next[3].c      = pr_c[36];
        p_next[3].mm     = 6'(p_reg[2].tmin - 11'(11'(p_reg[2].th) * 11'd60));
        p_next[3].hh_bcd = bcd2(7'(p_reg[2].hh));
        p_next[3].ss_bcd = bcd2(7'(p_reg[2].ss));
        p_next[3].ms_bcd = {p_reg[2].msh, bcd2(p_reg[2].msr)};
    end

    // Stage 4: corrected day count
    always_comb
    begin
        p_next[4]        = p_reg[3];
        p_next[4].t      = p_reg[3].doe - 18'(p_reg[3].a) + 18'(p_reg[3].b)
                           - 18'(p_reg[3].c);
        p_next[4].mm_bcd = bcd2(7'(p_reg[3].mm));
    end

    // Stage 5: year of era
    always_comb
    begin
        p_next[5]     = p_reg[4];
        pr_y          = 37'(p_reg[4].t) * 37'(M_365);
        p_next[5].yoe = pr_y[35:27];
    end

    // Stage 6: centuries in era
    always_comb
    begin
        p_next[6]    = p_reg[5];
        pr_yc        = 19'(p_reg[5].yoe) * 19'(M_Y100);
        p_next[6].yc = pr_yc[18:16];
    end

    // Stage 7: day of year, year from March
    always_comb
    begin
        p_next[7]     = p_reg[6];
        p_next[7].doy = 9'(p_reg[6].doe - 18'(18'(p_reg[6].yoe) * 18'd365)
                           - 18'(p_reg[6].yoe >> 2) + 18'(p_reg[6].yc));
        p_next[7].yp  = 12'(p_reg[6].yoe) + p_reg[6].y400;
    end

    // Stage 8
    always_comb
    begin
        p_next[8]   = p_reg[7];
        p_next[8].n = 11'(11'(p_reg[7].doy) * 11'd5) + 11'd2;
    end

    // Stage 9: month index from March
    always_comb
    begin
        p_next[9]    = p_reg[8];
        pr_mp        = 23'(p_reg[8].n) * 23'(M_153);
        p_next[9].mp = pr_mp[22:19];
    end

    // Stage 10
    always_comb
    begin
        p_next[10]   = p_reg[9];
        p_next[10].k = 11'(11'(p_reg[9].mp) * 11'd153) + 11'd2;
    end

    // Stage 11: day, month, civil year
    always_comb
    begin
        p_next[11]     = p_reg[10];
        pr_k           = 23'(p_reg[10].k) * 23'(M_5);
        q5             = pr_k[22:14];
        p_next[11].d   = 5'(p_reg[10].doy - q5 + 9'd1);
        p_next[11].mon = (p_reg[10].mp < 4'd10) ? (p_reg[10].mp + 4'd3)
                                                 : (p_reg[10].mp - 4'd9);
        p_next[11].year = p_reg[10].yp
                          + 12'((p_reg[10].mp >= 4'd10) ? 1 : 0) - 12'd400;
    end

    // Stage 12: year quotients, date digits
    always_comb
    begin
        p_next[12]        = p_reg[11];
        pr_10             = 25'(p_reg[11].year) * 25'(M_D10);
        pr_100            = 25'(p_reg[11].year) * 25'(M_D100);
        pr_1000           = 25'(p_reg[11].year) * 25'(M_D1000);
        p_next[12].q10    = pr_10[24:16];
        p_next[12].q100   = pr_100[24:19];
        p_next[12].q1000  = pr_1000[23:22];
        p_next[12].mo_bcd = bcd2(7'(p_reg[11].mon));
        p_next[12].dy_bcd = bcd2(7'(p_reg[11].d));
    end

    // Output: assemble all digits
    always_comb
    begin
        dig_next[0]  = 4'(p_reg[12].q1000);
        dig_next[1]  = 4'(p_reg[12].q100 - 6'(6'(p_reg[12].q1000) * 6'd10));
        dig_next[2]  = 4'(p_reg[12].q10 - 9'(9'(p_reg[12].q100) * 9'd10));
        dig_next[3]  = 4'(p_reg[12].year - 12'(12'(p_reg[12].q10) * 12'd10));
        dig_next[4]  = p_reg[12].mo_bcd[7:4];
        dig_next[5]  = p_reg[12].mo_bcd[3:0];
        dig_next[6]  = p_reg[12].dy_bcd[7:4];
        dig_next[7]  = p_reg[12].dy_bcd[3:0];
        dig_next[8]  = p_reg[12].hh_bcd[7:4];
        dig_next[9]  = p_reg[12].hh_bcd[3:0];
        dig_next[10] = p_reg[12].mm_bcd[7:4];
        dig_next[11] = p_reg[12].mm_bcd[3:0];
        dig_next[12] = p_reg[12].ss_bcd[7:4];
        dig_next[13] = p_reg[12].ss_bcd[3:0];
        dig_next[14] = p_reg[12].ms_bcd[11:8];
        dig_next[15] = p_reg[12].ms_bcd[7:4];
        dig_next[16] = p_reg[12].ms_bcd[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NST-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= NST; i++)
            p_reg[i] <= p_next[i];
        dig_reg <= dig_next;
    end

    assign out_valid  = vld_reg[NST];
    assign out_digits = dig_reg;

endmodule

`default_nettype wire

>>> hw/rtl/u2r_queue.sv
`default_nettype none

module u2r_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire u2r_pkg::digits_t  wr_data,
    input  wire logic              rd_en,
    output logic                   empty,
    output u2r_pkg::digits_t       rd_data
);
    import u2r_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    digits_t       mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        count_next = count_reg + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> hw/rtl/u2r_back.sv
`default_nettype none

module u2r_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire u2r_pkg::digits_t  q_head,
    output logic                   retire,
    input  wire logic              pop,
    output logic                   empty,
    output logic [7:0]             text_char,
    output logic [4:0]             char_position,
    output logic                   is_last
);
    import u2r_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] char_reg, char_next;
    logic [4:0] opos_reg, opos_next;
    logic       last_reg, last_next;
    logic       advance;

    assign advance = !out_valid_reg || pop;

    // Walk the head item one character per cycle while the output is free or popped
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        char_next      = char_reg;
        opos_next      = opos_reg;
        last_next      = last_reg;
        retire         = 1'b0;
        if (advance)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                char_next = char_at(pos_reg, q_head);
                opos_next = pos_reg;
                last_next = (pos_reg == LAST_POS);
                if (pos_reg == LAST_POS)
                begin
                    pos_next = '0;
                    retire   = 1'b1;
                end
                else
                    pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        opos_reg <= opos_next;
        last_reg <= last_next;
    end

    assign empty         = !out_valid_reg;
    assign text_char     = char_reg;
    assign char_position = opos_reg;
    assign is_last       = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/unix_ns_to_rfc3339_text.sv
`default_nettype none

// Converts signed Unix nanosecond timestamps into the 24-character UTC text
// YYYY-MM-DDThh:mm:ss.mmmZ, one character per popped item, with is_last set on
// the trailing Z. Times before the epoch are floored; sub-millisecond digits are
// truncated. The front divides by reciprocal multiplication (four folding steps
// for seconds, then days and milliseconds); a 13-stage pipeline does the
// calendar math and digit split; the back emits one character per cycle while
// the receiver pops. The sustained rate is set by the character output.
// A new timestamp is accepted while earlier ones are still in flight; QDEPTH
// sets how many finished timestamps may wait between the pipeline and the
// character output.
module unix_ns_to_rfc3339_text #(
    parameter int QDEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [63:0] timestamp_ns,
    output logic                    empty,
    input  wire logic               pop,
    output logic [7:0]              text_char,
    output logic [4:0]              char_position,
    output logic                    is_last
);
    import u2r_pkg::*;

    logic    launch;
    split_t  split;
    logic    civ_valid;
    digits_t civ_digits;
    logic    q_empty;
    digits_t q_head;
    logic    retire;

    u2r_front #(.QDEPTH(QDEPTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .timestamp_ns (timestamp_ns),
        .full         (full),
        .retire       (retire),
        .launch       (launch),
        .split        (split)
    );

    u2r_civil u_civil (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (launch),
        .in_split   (split),
        .out_valid  (civ_valid),
        .out_digits (civ_digits)
    );

    u2r_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (civ_valid),
        .wr_data (civ_digits),
        .rd_en   (retire),
        .empty   (q_empty),
        .rd_data (q_head)
    );

    u2r_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .retire        (retire),
        .pop           (pop),
        .empty         (empty),
        .text_char     (text_char),
        .char_position (char_position),
        .is_last       (is_last)
    );

endmodule

`default_nettype wire

>>> hw/rtl/u2r_check.sv
`default_nettype none

module u2r_check (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] text_char,
    input wire logic [4:0] char_position,
    input wire logic       is_last
);

    // Last flag marks exactly the final position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_last == (char_position == 5'd23)))
        else $error("is_last does not match final position");

    // Characters of one item come in order without gaps
    a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !is_last) |=>
            (!empty && char_position == $past(char_position) + 5'd1))
        else $error("character position skipped or stalled");

    // A new item starts at position zero
    a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && is_last) |=> (empty || char_position == 5'd0))
        else $error("item did not start at position zero");

    // Fixed separator
    a_sep: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (char_position == 5'd4 || char_position == 5'd7)) |->
            text_char == 8'h2D)
        else $error("date separator wrong");

    // A waiting item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(text_char) && $stable(char_position)))
        else $error("waiting item changed");

endmodule

bind unix_ns_to_rfc3339_text u2r_check u_check (.*);

`default_nettype wire

>>> tb/tb_unix_ns_to_rfc3339_text.sv
`default_nettype none

// Queue of expected timestamp characters, fed on push, drained on pop
class rfc3339_text_board;
    logic [7:0] exp_char[$];
    logic [4:0] exp_pos[$];
    logic       exp_last[$];
    int         mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Digits of v, n wide, into txt starting at p
    function void put_num(ref logic [7:0] txt[24], input int p, input longint v,
                          input int n);
        for (int i = n - 1; i >= 0; i--)
        begin
            txt[p + i] = 8'h30 + 8'(v % 10);
            v = v / 10;
        end
    endfunction

    // Format one timestamp and queue its 24 characters
    function void note_timestamp(input logic signed [63:0] ns);
        logic [7:0] txt[24];
        longint secs, rem, days, sod, z, era, doe, yoe, y, doy, mp, d, m;
        secs = ns / 1000000000;
        rem  = ns % 1000000000;
        if (rem < 0)
        begin
            rem  += 1000000000;
            secs -= 1;
        end
        days = (secs >= 0) ? secs / 86400 : (secs - 86399) / 86400;
        sod  = secs - days * 86400;
        // era-based day count to civil date
        z   = days + 719468;
        era = ((z >= 0) ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        y   = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        if (m <= 2)
            y += 1;
        if (y < 0)
            y = 0;
        put_num(txt, 0, y % 10000, 4);
        txt[4] = "-";
        put_num(txt, 5, m, 2);
        txt[7] = "-";
        put_num(txt, 8, d, 2);
        txt[10] = "T";
        put_num(txt, 11, sod / 3600, 2);
        txt[13] = ":";
        put_num(txt, 14, (sod / 60) % 60, 2);
        txt[16] = ":";
        put_num(txt, 17, sod % 60, 2);
        txt[19] = ".";
        put_num(txt, 20, rem / 1000000, 3);
        txt[23] = "Z";
        for (int k = 0; k < 24; k++)
        begin
            exp_char.push_back(txt[k]);
            exp_pos.push_back(5'(k));
            exp_last.push_back(k == 23);
        end
    endfunction

    // Compare one popped item with the oldest expected character
    function void check_char(input logic [7:0] c, input logic [4:0] p, input logic l);
        logic [7:0] ec;
        logic [4:0] ep;
        logic       el;
        if (exp_char.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: char %h pos %0d last %b", c, p, l);
            return;
        end
        ec = exp_char.pop_front();
        ep = exp_pos.pop_front();
        el = exp_last.pop_front();
        if (c !== ec || p !== ep || l !== el)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp char %h pos %0d last %b, got %h %0d %b",
                         ec, ep, el, c, p, l);
        end
    endfunction
endclass

module tb_unix_ns_to_rfc3339_text;
    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [63:0] timestamp_ns;
    logic               empty;
    logic               pop;
    logic [7:0]         text_char;
    logic [4:0]         char_position;
    logic               is_last;

    rfc3339_text_board board;
    logic signed [63:0] stamps[$];
    int                 idle_cycles;
    int                 pop_wait;

    unix_ns_to_rfc3339_text dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .timestamp_ns(timestamp_ns), .empty(empty), .pop(pop),
        .text_char(text_char), .char_position(char_position), .is_last(is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Push one timestamp, holding it until accepted
    task automatic send_stamp(input logic signed [63:0] v);
        push         <= 1'b1;
        timestamp_ns <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_timestamp(v);
    endtask

    task automatic send_all();
        int g;
        foreach (stamps[i])
        begin
            send_stamp(stamps[i]);
            g = gap_len();
            if (g > 0)
            begin
                push <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
        push <= 1'b0;
    endtask

    // Random timestamp: full range, near epoch, near ends, odd remainders
    function automatic logic signed [63:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return r;
            1: return $signed(r) >>> $urandom_range(20, 62);
            2: return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom);
            3: return 64'h8000_0000_0000_0000 + 64'($urandom);
            default: return 64'((longint'($urandom_range(0, 200000)) - 100000)
                                * 86400 * 1000000000 + 64'($urandom_range(0, 999999999)));
        endcase
    endfunction

    // Receiver: random pop with gaps, mostly short and a few long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_wait <= 0;
        end
        else
        begin
            if (pop && !empty)
                board.check_char(text_char, char_position, is_last);
            if (pop_wait > 0)
            begin
                pop      <= 1'b0;
                pop_wait <= pop_wait - 1;
            end
            else if ($urandom_range(0, 99) < 70)
                pop <= 1'b1;
            else
            begin
                pop      <= 1'b0;
                pop_wait <= gap_len();
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("tb_unix_ns_to_rfc3339_text failed");
            $finish;
        end
    end

    initial
    begin
        board        = new();
        push         = 1'b0;
        timestamp_ns = '0;
        rst_n        = 1'b0;
        idle_cycles  = 0;
        // directed: range ends, epoch, sign of remainder, truncation, leap days
        stamps.push_back(64'h8000_0000_0000_0000);
        stamps.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        stamps.push_back(64'sd0);
        stamps.push_back(-64'sd1);
        stamps.push_back(64'sd1);
        stamps.push_back(64'sd999999);
        stamps.push_back(64'sd1000000);
        stamps.push_back(64'sd999999999);
        stamps.push_back(-64'sd1000000000);
        stamps.push_back(-64'sd1000000001);
        stamps.push_back(64'sd86399999999999);
        stamps.push_back(-64'sd86400000000000);
        stamps.push_back(-64'sd86400000000001);
        stamps.push_back(64'sd951782400000000000);
        stamps.push_back(64'sd951868799999999999);
        stamps.push_back(64'sd4107542400000000000);
        stamps.push_back(64'sd946684799999999999);
        stamps.push_back(64'sd1709164800123456789);
        stamps.push_back(-64'sd2208988800000000000);
        stamps.push_back(64'sh5555_5555_5555_5555);
        stamps.push_back(64'shAAAA_AAAA_AAAA_AAAA);
        for (int i = 0; i < 390; i++)
            stamps.push_back(rand_stamp());
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_all();
        while (board.exp_char.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.mismatches == 0 && board.exp_char.size() == 0)
            $display("tb_unix_ns_to_rfc3339_text passed");
        else
            $display("tb_unix_ns_to_rfc3339_text failed");
        $finish;
    end
endmodule

`default_nettype wire
